>>> sv/bpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the block projection checksum.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int DATA_W = 8;
    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_ROW   = 2'd1,
        KIND_COL   = 2'd2,
        KIND_TOTAL = 2'd3
    } kind_t;

    // Control from the top level to the sum accumulator.
    typedef struct packed {
        logic take;   // input request accepted this cycle
        logic shift;  // trailer head consumed this cycle
    } acc_ctrl_t;

endpackage
`default_nettype wire

>>> sv/bpc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_in_if
// Valid/ready channel carrying one data byte per request.
// ----------------------------------------------------------------------------
interface bpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

>>> sv/bpc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_out_if
// Valid/ready channel carrying one data or checksum byte per request.
// ----------------------------------------------------------------------------
interface bpc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface
`default_nettype wire

>>> sv/block_projection_checksum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_projection_checksum
// Byte stream pass-through with a row/column/total checksum trailer per block.
// ----------------------------------------------------------------------------
// Each accepted byte is forwarded as a data request the next cycle through an
// output register, so a byte can be taken every cycle while the output side
// keeps up. After every LINE_LEN*LINE_LEN bytes the block sends its trailer:
// LINE_LEN row sums, LINE_LEN column sums, then the total (all mod 256), the
// last of these flagged with last=1. The finished sums are copied into a
// snapshot shift register, and input is held off while the 2*LINE_LEN+1
// trailer requests go out on the output port. A partial block produces no
// trailer.
// ----------------------------------------------------------------------------
module block_projection_checksum #(
    parameter int LINE_LEN = 4
) (
    input  wire          clk,
    input  wire          rst_n,
    bpc_in_if.sink       feed,
    bpc_out_if.source    result
);
    import bpc_pkg::*;

    localparam int CW = $clog2(2 * LINE_LEN + 1);
    localparam logic [CW-1:0] CNT_COL   = CW'(LINE_LEN);
    localparam logic [CW-1:0] CNT_TOTAL = CW'(2 * LINE_LEN);

    acc_ctrl_t         ctrl;
    logic              block_end;
    logic [DATA_W-1:0] trail_head;
    logic [DATA_W-1:0] trail_total;

    logic              load;
    logic              take;
    logic              emit;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_byte_reg;
    kind_t             kind_reg;
    logic              last_reg;
    logic              trail_active_reg;
    logic [CW-1:0]     trail_cnt_reg;

    assign load = !out_valid_reg || result.ready;
    assign take = feed.valid && feed.ready;
    assign emit = trail_active_reg && load;

    assign feed.ready = load && !trail_active_reg;

    assign ctrl.take  = take;
    assign ctrl.shift = emit && (trail_cnt_reg != CNT_TOTAL);

    bpc_accum #(
        .LINE_LEN (LINE_LEN)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .data        (feed.data_byte),
        .block_end   (block_end),
        .trail_head  (trail_head),
        .trail_total (trail_total)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            trail_active_reg <= 1'b0;
            trail_cnt_reg    <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= take || emit;
            end
            if (take && block_end)
            begin
                trail_active_reg <= 1'b1;
                trail_cnt_reg    <= '0;
            end
            else if (emit)
            begin
                if (trail_cnt_reg == CNT_TOTAL)
                begin
                    trail_active_reg <= 1'b0;
                end
                trail_cnt_reg <= trail_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_byte_reg <= feed.data_byte;
            kind_reg     <= KIND_DATA;
            last_reg     <= !block_end;
        end
        else if (emit)
        begin
            priority if (trail_cnt_reg == CNT_TOTAL)
            begin
                out_byte_reg <= trail_total;
                kind_reg     <= KIND_TOTAL;
                last_reg     <= 1'b1;
            end
            else if (trail_cnt_reg < CNT_COL)
            begin
                out_byte_reg <= trail_head;
                kind_reg     <= KIND_ROW;
                last_reg     <= 1'b0;
            end
            else
            begin
                out_byte_reg <= trail_head;
                kind_reg     <= KIND_COL;
                last_reg     <= 1'b0;
            end
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.kind     = kind_reg;
    assign result.last     = last_reg;

    // No input while the trailer drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        trail_active_reg |-> !feed.ready)
        else $error("input accepted during trailer");

    // A data byte that closes a block is followed directly by the first row sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.kind == KIND_DATA && !result.last)
        |=> (result.valid && result.kind == KIND_ROW))
        else $error("trailer does not follow block end");

    // The total closes the trailer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.kind == KIND_TOTAL) |-> (result.last && !trail_active_reg))
        else $error("total request malformed");

    // Trailer counter stays in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        trail_cnt_reg <= CNT_TOTAL + 1'b1)
        else $error("trailer counter out of range");

endmodule
`default_nettype wire

>>> sv/bpc_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_accum
// Row, column and total sums of the current block, plus a snapshot shift
// register that holds the finished block's sums while the trailer drains.
// ----------------------------------------------------------------------------
module bpc_accum #(
    parameter int LINE_LEN = 4
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire bpc_pkg::acc_ctrl_t   ctrl,
    input  wire [bpc_pkg::DATA_W-1:0] data,
    output logic                      block_end,
    output logic [bpc_pkg::DATA_W-1:0] trail_head,
    output logic [bpc_pkg::DATA_W-1:0] trail_total
);
    import bpc_pkg::*;

    localparam int IW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(LINE_LEN - 1);
    localparam int TRAIL_N = 2 * LINE_LEN;

    logic [IW-1:0]     row_idx_reg;
    logic [IW-1:0]     col_idx_reg;
    logic [DATA_W-1:0] row_sum_reg [LINE_LEN];
    logic [DATA_W-1:0] col_sum_reg [LINE_LEN];
    logic [DATA_W-1:0] row_sum_next [LINE_LEN];
    logic [DATA_W-1:0] col_sum_next [LINE_LEN];
    logic [DATA_W-1:0] total_reg;
    logic [DATA_W-1:0] total_next;
    logic [DATA_W-1:0] snap_reg [TRAIL_N];
    logic [DATA_W-1:0] snap_total_reg;

    assign block_end   = (row_idx_reg == LAST_IDX) && (col_idx_reg == LAST_IDX);
    assign trail_head  = snap_reg[0];
    assign trail_total = snap_total_reg;

    // Every byte lands once in a row sum and once in a column sum.
    assign total_next = total_reg + {data[DATA_W-2:0], 1'b0};

    always_comb
    begin
        for (int i = 0; i < LINE_LEN; i++)
        begin
            row_sum_next[i] = (row_idx_reg == IW'(i)) ? row_sum_reg[i] + data : row_sum_reg[i];
            col_sum_next[i] = (col_idx_reg == IW'(i)) ? col_sum_reg[i] + data : col_sum_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_idx_reg <= '0;
            col_idx_reg <= '0;
            total_reg   <= '0;
            for (int i = 0; i < LINE_LEN; i++)
            begin
                row_sum_reg[i] <= '0;
                col_sum_reg[i] <= '0;
            end
        end
        else if (ctrl.take)
        begin
            if (block_end)
            begin
                row_idx_reg <= '0;
                col_idx_reg <= '0;
                total_reg   <= '0;
                for (int i = 0; i < LINE_LEN; i++)
                begin
                    row_sum_reg[i] <= '0;
                    col_sum_reg[i] <= '0;
                end
            end
            else
            begin
                total_reg <= total_next;
                for (int i = 0; i < LINE_LEN; i++)
                begin
                    row_sum_reg[i] <= row_sum_next[i];
                    col_sum_reg[i] <= col_sum_next[i];
                end
                if (col_idx_reg == LAST_IDX)
                begin
                    col_idx_reg <= '0;
                    row_idx_reg <= row_idx_reg + 1'b1;
                end
                else
                begin
                    col_idx_reg <= col_idx_reg + 1'b1;
                end
            end
        end
    end

    // Snapshot: rows then columns, shifted toward entry 0 as they are sent.
    always_ff @(posedge clk)
    begin
        if (ctrl.take && block_end)
        begin
            snap_total_reg <= total_next;
            for (int i = 0; i < LINE_LEN; i++)
            begin
                snap_reg[i]            <= row_sum_next[i];
                snap_reg[LINE_LEN + i] <= col_sum_next[i];
            end
        end
        else if (ctrl.shift)
        begin
            for (int i = 0; i < TRAIL_N - 1; i++)
            begin
                snap_reg[i] <= snap_reg[i + 1];
            end
        end
    end

endmodule
`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for block_projection_checksum. Bytes are sent through
// the feed channel with random gaps while the result side stalls at random.
// A running model of the row and column sums turns each accepted request into
// the expected data byte and, at the end of a block, the row/column/total
// trailer. Every result request is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    import bpc_pkg::*;

    localparam int LINE_LEN    = 4;
    localparam int GRID_BYTES  = LINE_LEN * LINE_LEN;
    localparam int DRAIN_WAIT  = 2 * LINE_LEN + 8;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        kind_t             kind;
        logic              last;
    } out_req_t;

    logic clk;
    logic rst_n;

    bpc_in_if  feed_if ();
    bpc_out_if res_if ();

    block_projection_checksum #(
        .LINE_LEN (LINE_LEN)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_if),
        .result (res_if)
    );

    out_req_t          pending_q[$];
    logic [DATA_W-1:0] row_sum [LINE_LEN];
    logic [DATA_W-1:0] col_sum [LINE_LEN];
    int                grid_pos;
    int                error_count;
    int                cycle_count;
    int                stall_left;
    bit                idle_on;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("block_projection_checksum test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void push_result(input logic [DATA_W-1:0] v, input kind_t k,
                                        input logic l);
        out_req_t r;
        r.value = v;
        r.kind  = k;
        r.last  = l;
        pending_q.push_back(r);
    endfunction

    function automatic void predict_checksum(input logic [DATA_W-1:0] b);
        int                row;
        int                col;
        logic [DATA_W-1:0] total;
        row = grid_pos / LINE_LEN;
        col = grid_pos % LINE_LEN;
        row_sum[row] = row_sum[row] + b;
        col_sum[col] = col_sum[col] + b;
        if (grid_pos + 1 < GRID_BYTES)
        begin
            grid_pos++;
            push_result(b, KIND_DATA, 1'b1);
        end
        else
        begin
            total = '0;
            push_result(b, KIND_DATA, 1'b0);
            for (int i = 0; i < LINE_LEN; i++)
            begin
                push_result(row_sum[i], KIND_ROW, 1'b0);
                total = total + row_sum[i];
            end
            for (int i = 0; i < LINE_LEN; i++)
            begin
                push_result(col_sum[i], KIND_COL, 1'b0);
                total = total + col_sum[i];
            end
            push_result(total, KIND_TOTAL, 1'b1);
            for (int i = 0; i < LINE_LEN; i++)
            begin
                row_sum[i] = '0;
                col_sum[i] = '0;
            end
            grid_pos = 0;
        end
    endfunction

    // Sink side: ready with random stall bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            res_if.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= 1'b1;
        end
    end

    // Predict on accepted input, check each accepted result.
    always @(posedge clk)
    begin
        out_req_t want;
        if (rst_n)
        begin
            if (feed_if.valid && feed_if.ready)
                predict_checksum(feed_if.data_byte);
            if (res_if.valid && res_if.ready)
            begin
                if (pending_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected request out_byte=%02h kind=%0d last=%0b",
                                              res_if.out_byte, res_if.kind, res_if.last));
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (res_if.out_byte !== want.value)
                        report_mismatch($sformatf("out_byte got %02h want %02h (kind %0d)",
                                                  res_if.out_byte, want.value, want.kind));
                    if (res_if.kind !== want.kind)
                        report_mismatch($sformatf("kind got %0d want %0d",
                                                  res_if.kind, want.kind));
                    if (res_if.last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b (kind %0d)",
                                                  res_if.last, want.last, want.kind));
                end
            end
        end
    end

    task automatic send_byte(input logic [DATA_W-1:0] b);
        int gap;
        feed_if.valid     <= 1'b1;
        feed_if.data_byte <= b;
        @(posedge clk);
        while (!feed_if.ready)
            @(posedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            feed_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        feed_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return DATA_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Full block of 0xFF: largest sums, every sum wraps.
    task automatic test_saturated_block();
        for (int i = 0; i < GRID_BYTES; i++)
            send_byte(8'hFF);
    endtask

    // Partial block must not produce a trailer; the rest follows later.
    task automatic test_partial_block();
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(8'h55);
        wait_drained();
    endtask

    task automatic test_random_stream(input int count);
        for (int i = 0; i < count; i++)
            send_byte(pick_byte());
    endtask

    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        for (int i = 0; i < count; i++)
            send_byte(pick_byte());
    endtask

    initial
    begin
        rst_n             = 1'b0;
        feed_if.valid     = 1'b0;
        feed_if.data_byte = '0;
        res_if.ready      = 1'b0;
        idle_on           = 1'b1;
        stall_left        = 0;
        error_count       = 0;
        cycle_count       = 0;
        grid_pos          = 0;
        for (int i = 0; i < LINE_LEN; i++)
        begin
            row_sum[i] = '0;
            col_sum[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_saturated_block();
        test_partial_block();
        test_random_stream(200);
        test_back_to_back(43);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("block_projection_checksum test passed");
        else
            $display("block_projection_checksum test failed");
        $finish;
    end
endmodule

>>> block_projection_checksum.f
sv/bpc_pkg.sv
sv/bpc_in_if.sv
sv/bpc_out_if.sv
sv/bpc_accum.sv
sv/block_projection_checksum.sv
bench/tb.sv
